// ----- rtl/skm_pkg.sv -----
// Package with shared constants and defaults for the stream keyword set matcher.
`timescale 1ns / 1ps

package skm_pkg;

    localparam int MAX_WORDS_DEF   = 7;
    localparam int MAX_LETTERS_DEF = 8;

    localparam int WORD_W     = 64;
    localparam int BYTE_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int COUNT_W    = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_WORD_COUNT = 3'd7;

    localparam logic [BYTE_W-1:0] UPPER_FIRST = 8'd65;
    localparam logic [BYTE_W-1:0] UPPER_LAST  = 8'd90;
    localparam logic [BYTE_W-1:0] LOWER_FIRST = 8'd97;
    localparam logic [BYTE_W-1:0] LOWER_LAST  = 8'd122;

    function automatic logic is_letter(input logic [BYTE_W-1:0] b);
        return ((b >= UPPER_FIRST) && (b <= UPPER_LAST)) ||
               ((b >= LOWER_FIRST) && (b <= LOWER_LAST));
    endfunction

endpackage

// ----- rtl/skm_word_match.sv -----
// Token against search word comparison with lowest-index priority and the all-found check.
`timescale 1ns / 1ps

module skm_word_match import skm_pkg::*; #(
    parameter int MAX_WORDS   = MAX_WORDS_DEF,
    parameter int MAX_LETTERS = MAX_LETTERS_DEF
) (
    input  logic [MAX_WORDS-1:0][WORD_W-1:0] i_words,
    input  logic [COUNT_W-1:0]               i_word_count,
    input  logic [BYTE_W*MAX_LETTERS-1:0]    i_token,
    input  logic                             i_token_overflow,
    input  logic [MAX_WORDS-1:0]             i_found,
    output logic [MAX_WORDS-1:0]             o_found,
    output logic                             o_all_found
);

    localparam int TOK_W = BYTE_W * MAX_LETTERS;

    logic [WORD_W-1:0]    tok_ext;
    logic [COUNT_W-1:0]   active;
    logic [MAX_WORDS-1:0] mask;
    logic [MAX_WORDS-1:0] hit;
    logic [MAX_WORDS-1:0] first_hit;
    logic                 taken;

    always_comb begin
        tok_ext = '0;
        tok_ext[TOK_W-1:0] = i_token;
        if (i_word_count > COUNT_W'(MAX_WORDS)) begin
            active = COUNT_W'(MAX_WORDS);
        end else begin
            active = i_word_count;
        end
        taken = 1'b0;
        for (int i = 0; i < MAX_WORDS; i++) begin
            mask[i] = (COUNT_W'(i) < active);
            hit[i] = mask[i] && !i_token_overflow && (i_words[i] == tok_ext);
            first_hit[i] = hit[i] && !taken;
            taken = taken | hit[i];
        end
        o_found = i_found | first_hit;
        o_all_found = ((o_found & mask) == mask);
    end

endmodule

// ----- rtl/stream_keyword_set_matcher.sv -----
// Top level of the stream keyword set matcher: token builder, state and result register.
//
//   channel  direction  handshake                  payload
//   input    in         i_in_valid / o_in_ready    i_char_byte, i_is_end
//   result   out        o_out_valid / i_out_ready  o_all_found, o_file_done
//   config   in         i_cfg_we (no wait)         i_cfg_addr, i_cfg_data
//
// Each input beat gives one result beat, held in the result register from the cycle after it is taken.
// A new beat is taken every cycle while the result register is empty or being taken.
// The token, found flags and result register sit behind one level of compare logic.
// Synchronous active-low reset clears the word registers and all per-file state.
// A stalled result holds its register and stops the input only while it waits.
`timescale 1ns / 1ps

module stream_keyword_set_matcher import skm_pkg::*; #(
    parameter int MAX_WORDS   = MAX_WORDS_DEF,
    parameter int MAX_LETTERS = MAX_LETTERS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [WORD_W-1:0]     i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [BYTE_W-1:0]     i_char_byte,
    input  logic                  i_is_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_all_found,
    output logic                  o_file_done
);

    localparam int TOK_W = BYTE_W * MAX_LETTERS;
    localparam int LEN_W = $clog2(MAX_LETTERS + 1);

    logic [MAX_WORDS-1:0][WORD_W-1:0] r_words;
    logic [COUNT_W-1:0]               r_count;
    logic [TOK_W-1:0]                 r_token;
    logic [TOK_W-1:0]                 n_token;
    logic [LEN_W-1:0]                 r_tok_len;
    logic [LEN_W-1:0]                 n_tok_len;
    logic                             r_overflow;
    logic                             n_overflow;
    logic [MAX_WORDS-1:0]             r_found;
    logic [MAX_WORDS-1:0]             n_found;
    logic                             r_reported;
    logic                             n_reported;
    logic                             r_out_valid;
    logic                             r_all_found;
    logic                             r_file_done;

    logic                 accept;
    logic                 letter;
    logic                 pulse;
    logic [MAX_WORDS-1:0] match_found;
    logic                 match_all;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign letter      = !i_is_end && is_letter(i_char_byte);
    assign o_out_valid = r_out_valid;
    assign o_all_found = r_all_found;
    assign o_file_done = r_file_done;

    skm_word_match #(
        .MAX_WORDS   (MAX_WORDS),
        .MAX_LETTERS (MAX_LETTERS)
    ) u_match (
        .i_words          (r_words),
        .i_word_count     (r_count),
        .i_token          (r_token),
        .i_token_overflow (r_overflow),
        .i_found          (r_found),
        .o_found          (match_found),
        .o_all_found      (match_all)
    );

    always_comb begin
        n_token    = r_token;
        n_tok_len  = r_tok_len;
        n_overflow = r_overflow;
        n_found    = r_found;
        n_reported = r_reported;
        pulse      = 1'b0;
        if (!r_reported) begin
            if (letter) begin
                if (r_tok_len < LEN_W'(MAX_LETTERS)) begin
                    for (int k = 0; k < MAX_LETTERS; k++) begin
                        if (r_tok_len == LEN_W'(k)) begin
                            n_token[k*BYTE_W +: BYTE_W] = i_char_byte;
                        end
                    end
                    n_tok_len = r_tok_len + LEN_W'(1);
                end else begin
                    n_overflow = 1'b1;
                end
            end else begin
                n_found    = match_found;
                n_token    = '0;
                n_tok_len  = '0;
                n_overflow = 1'b0;
                pulse      = match_all;
                n_reported = match_all;
            end
        end
        if (i_is_end) begin
            n_token    = '0;
            n_tok_len  = '0;
            n_overflow = 1'b0;
            n_found    = '0;
            n_reported = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words     <= '0;
            r_count     <= '0;
            r_token     <= '0;
            r_tok_len   <= '0;
            r_overflow  <= 1'b0;
            r_found     <= '0;
            r_reported  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                for (int i = 0; i < MAX_WORDS; i++) begin
                    if (i_cfg_addr == CFG_ADDR_W'(i)) begin
                        r_words[i] <= i_cfg_data;
                    end
                end
                if (i_cfg_addr == CFG_WORD_COUNT) begin
                    r_count <= i_cfg_data[COUNT_W-1:0];
                end
            end
            if (accept) begin
                r_token     <= n_token;
                r_tok_len   <= n_tok_len;
                r_overflow  <= n_overflow;
                r_found     <= n_found;
                r_reported  <= n_reported;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_all_found <= pulse;
            r_file_done <= i_is_end;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_is_end |=> (r_found == '0) && !r_reported && (r_tok_len == '0))
        else $error("End beat did not clear the per-file state.");

    a_pulse_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && pulse && !i_is_end |=> r_reported && o_all_found)
        else $error("All-found beat did not set the reported flag.");

    a_reported_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reported |-> (r_tok_len == '0) && !r_overflow)
        else $error("Token holds letters after all words were found.");

    a_no_second_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_reported |=> !o_all_found)
        else $error("All-found repeated within one file.");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the stream keyword set matcher against a predictor of its results.
`timescale 1ns / 1ps

module testbench;
    import skm_pkg::*;

    localparam int RANDOM_BEATS = 1400;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } t_byte_beat;

    typedef struct packed {
        logic all_found;
        logic file_done;
    } t_match_result;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [WORD_W-1:0]     i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [BYTE_W-1:0]     i_char_byte = '0;
    logic                  i_is_end    = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_all_found;
    logic                  o_file_done;

    stream_keyword_set_matcher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_byte (i_char_byte),
        .i_is_end    (i_is_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_all_found (o_all_found),
        .o_file_done (o_file_done)
    );

    t_byte_beat    byte_stream[$];
    t_match_result predicted_results[$];
    t_byte_beat    next_beat;

    logic [WORD_W-1:0]  search_word [MAX_WORDS_DEF];
    logic [COUNT_W-1:0] active_count = '0;
    logic [WORD_W-1:0]  tok_letters  = '0;
    logic [3:0]         tok_len      = '0;
    logic               tok_long     = 1'b0;
    logic [6:0]         found_mask   = '0;
    logic               pulse_given  = 1'b0;

    logic idle_mode = 1'b1;
    int   send_wait = 0;
    int   recv_wait = 0;
    int   results_seen = 0;
    int   beats_queued = 0;
    int   mismatch_count = 0;
    int   cycle_count = 0;

    initial begin
        for (int i = 0; i < MAX_WORDS_DEF; i++) search_word[i] = '0;
    end

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic is_alpha(input logic [BYTE_W-1:0] b);
        return ((b >= UPPER_FIRST) && (b <= UPPER_LAST)) ||
               ((b >= LOWER_FIRST) && (b <= LOWER_LAST));
    endfunction

    function automatic logic [BYTE_W-1:0] rand_letter();
        return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(65, 90))
                                           : 8'($urandom_range(97, 122));
    endfunction

    function automatic logic [BYTE_W-1:0] rand_separator();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom);
        while (is_alpha(b)) b = 8'($urandom);
        return b;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word(input int len);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int k = 0; k < len; k++) w[8*k +: 8] = rand_letter();
        return w;
    endfunction

    task automatic predict_match_result(input logic [BYTE_W-1:0] ch, input logic last);
        t_match_result r;
        logic          hit;
        logic [7:0]    need;
        r.all_found = 1'b0;
        r.file_done = last;
        if (!pulse_given) begin
            if (!last && is_alpha(ch)) begin
                if (tok_len < MAX_LETTERS_DEF) begin
                    tok_letters[8*tok_len +: 8] = ch;
                    tok_len = tok_len + 4'd1;
                end else begin
                    tok_long = 1'b1;
                end
            end else begin
                hit = 1'b0;
                for (int i = 0; i < MAX_WORDS_DEF; i++) begin
                    if (!hit && !tok_long && i < active_count && search_word[i] == tok_letters) begin
                        found_mask[i] = 1'b1;
                        hit = 1'b1;
                    end
                end
                tok_letters = '0;
                tok_len     = '0;
                tok_long    = 1'b0;
                need = (8'd1 << active_count) - 8'd1;
                if (({1'b0, found_mask} & need) == need) begin
                    pulse_given = 1'b1;
                    r.all_found = 1'b1;
                end
            end
        end
        if (last) begin
            tok_letters = '0;
            tok_len     = '0;
            tok_long    = 1'b0;
            found_mask  = '0;
            pulse_given = 1'b0;
        end
        predicted_results.push_back(r);
    endtask

    task automatic push_beat(input logic [BYTE_W-1:0] ch, input logic last);
        t_byte_beat b;
        b.ch   = ch;
        b.last = last;
        byte_stream.push_back(b);
        beats_queued++;
    endtask

    task automatic push_word(input logic [WORD_W-1:0] w);
        for (int k = 0; k < 8; k++) begin
            if (w[8*k +: 8] != 8'd0) push_beat(w[8*k +: 8], 1'b0);
        end
    endtask

    task automatic wait_drained();
        while (byte_stream.size() != 0 || results_seen < beats_queued)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        if (idx == CFG_WORD_COUNT) active_count = val[COUNT_W-1:0];
        else search_word[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_random_file(input logic with_end);
        int n;
        int ntok;
        int nsep;
        int r;
        n = active_count;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(5, 30)) push_beat(8'($urandom), 1'b0);
        end else begin
            ntok = $urandom_range(1, 16);
            for (int t = 0; t < ntok; t++) begin
                r = $urandom_range(0, 9);
                if (r < 7 && n > 0) begin
                    push_word(search_word[$urandom_range(0, n - 1)]);
                end else if (r < 9) begin
                    repeat ($urandom_range(1, 11)) push_beat(rand_letter(), 1'b0);
                end
                nsep = (t == ntok - 1) ? $urandom_range(0, 2) : $urandom_range(1, 2);
                repeat (nsep) push_beat(rand_separator(), 1'b0);
            end
        end
        if (with_end) push_beat(8'($urandom), 1'b1);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_match_result(i_char_byte, i_is_end);
                send_wait = idle_mode ? $urandom_range(0, 7) : 0;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (byte_stream.size() > 0) begin
                    next_beat = byte_stream.pop_front();
                    i_in_valid  <= 1'b1;
                    i_char_byte <= next_beat.ch;
                    i_is_end    <= next_beat.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t unexpected beat: all_found=%b file_done=%b",
                             $time, o_all_found, o_file_done);
                    mismatch_count++;
                end else if (o_all_found !== predicted_results[0].all_found ||
                             o_file_done !== predicted_results[0].file_done) begin
                    $display("%0t mismatch: expected all_found=%b file_done=%b, got %b %b",
                             $time, predicted_results[0].all_found,
                             predicted_results[0].file_done, o_all_found, o_file_done);
                    mismatch_count++;
                    void'(predicted_results.pop_front());
                end else begin
                    void'(predicted_results.pop_front());
                end
                results_seen++;
                if (results_seen == HOLD_AT) recv_wait = HOLD_CYCLES;
                else recv_wait = idle_mode ? $urandom_range(0, 7) : 0;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int                n;
        int                len;
        int                r;
        int                rand_start;
        logic [WORD_W-1:0] w;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With no active words the first close reports, and later bytes are ignored.
        push_beat("q", 1'b0);
        push_beat(8'h20, 1'b0);
        push_beat("x", 1'b0);
        push_beat(8'h00, 1'b1);
        wait_drained();

        set_reg(3'(0), 64'h7A61_5A41);
        set_reg(3'(1), 64'h7A7A_7A7A_7A7A_7A7A);
        set_reg(3'(2), 64'h0);
        set_reg(3'(3), 64'h7A61_5A41);
        set_reg(3'(4), 64'hFFFF_FFFF_FFFF_FFFF);
        set_reg(3'(5), 64'h42_0041);
        set_reg(3'(6), 64'h4141_4141_4141_4141);
        set_reg(CFG_WORD_COUNT, 64'd3);

        // Empty token matches the zero word; the end mark closes the last word and reports.
        push_word(64'h7A61_5A41);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_word(64'h7A7A_7A7A_7A7A_7A7A);
        push_beat(8'hFF, 1'b1);
        wait_drained();

        // All seven active with a duplicate: an overlong token matches nothing.
        set_reg(CFG_WORD_COUNT, 64'd7);
        repeat (9) push_beat("z", 1'b0);
        push_beat(8'h7F, 1'b1);
        wait_drained();

        rand_start = beats_queued;
        while (beats_queued - rand_start < RANDOM_BEATS) begin
            wait_drained();
            idle_mode <= ($urandom_range(0, 3) != 0);
            for (int i = 0; i < MAX_WORDS_DEF; i++) begin
                r   = $urandom_range(0, 19);
                len = ($urandom_range(0, 2) == 0) ? MAX_LETTERS_DEF : $urandom_range(1, 8);
                if (r == 0) begin
                    w = '0;
                end else if (r == 1 && i > 0) begin
                    w = search_word[$urandom_range(0, i - 1)];
                end else if (r == 2) begin
                    w = {$urandom, $urandom};
                end else if (r == 3 && len > 1) begin
                    w = rand_word(len);
                    w[8*$urandom_range(0, len - 2) +: 8] = 8'd0;
                end else begin
                    w = rand_word(len);
                end
                set_reg(3'(i), w);
            end
            r = $urandom_range(0, 9);
            n = (r < 8) ? $urandom_range(1, 4) : ((r == 8) ? 0 : MAX_WORDS_DEF);
            set_reg(CFG_WORD_COUNT, 64'(n));
            n = $urandom_range(2, 5);
            for (int f = 0; f < n; f++)
                push_random_file(!(f == n - 1 && $urandom_range(0, 4) == 0));
        end

        wait_drained();
        if (predicted_results.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/skm_pkg.sv
rtl/skm_word_match.sv
rtl/stream_keyword_set_matcher.sv
tb/testbench.sv
